FILE: design/fpp_pkg.sv
// ----------------------------------------------------------------------------
// fpp_pkg
// shared types, register indexes and constants of the fisheye projection core
// ----------------------------------------------------------------------------
package fpp_pkg;

   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_FOCAL_X  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FOCAL_Y  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_X = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_Y = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_DIST_K1  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_DIST_K2  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_DIST_K3  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_DIST_K4  = 3'd7;

   localparam int SQRT_STEPS = 32;
   localparam int ANG_STEPS  = 32;

   // pi * 2^31, turns binary angle units into radians
   localparam logic [32:0] PI_Q31 = 33'd6746518852;
   localparam logic [41:0] ONE_Q28 = 42'd1 << 28;

   // atan(2^-i) in binary angle units, 2^32 per turn
   localparam logic [31:0] ATAN_BAM [ANG_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic zr;
   } flags_type;

   typedef struct packed {
      flags_type   flags;
      logic [31:0] ax;
      logic [31:0] ay;
      logic [62:0] az;
   } sq_side_type;

   function automatic logic [5:0] msb_index(input logic [63:0] v);
      logic [5:0] idx;
      idx = '0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            idx = i[5:0];
         end
      end
      return idx;
   endfunction

endpackage

FILE: design/fisheye_point_projection_core.sv
// ----------------------------------------------------------------------------
// fisheye_point_projection_core
// equidistant fisheye projection of camera-space points to pixel coordinates
// ----------------------------------------------------------------------------
// Takes one point per clock while req_ready is high and returns one pixel
// word per point, in order. The pipeline is made of the 32-stage square root
// and the 32-stage angle cordic, each doing one step per stage, plus the
// polynomial and scaling multipliers. Results go to an output register with
// a one-word skid stage, so points keep entering while a result waits; input
// ready drops only once the skid stage is full. Configuration is sampled
// live by the stages, so write it only while no point is in flight.
module fisheye_point_projection_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [31:0]              req_point_x,
   input  logic signed [31:0]              req_point_y,
   input  logic signed [31:0]              req_point_z,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [31:0]              rsp_pixel_x,
   output logic signed [31:0]              rsp_pixel_y,
   output logic                            rsp_clipped,
   input  logic                            csr_write_en,
   input  logic [fpp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                     csr_wdata
);

   // configuration
   logic [31:0] focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   logic [31:0] k_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= 32'd65536;
         focal_y_ff  <= 32'd65536;
         center_x_ff <= '0;
         center_y_ff <= '0;
         k_ff[0]     <= '0;
         k_ff[1]     <= '0;
         k_ff[2]     <= '0;
         k_ff[3]     <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            fpp_pkg::REG_FOCAL_X:  focal_x_ff  <= csr_wdata;
            fpp_pkg::REG_FOCAL_Y:  focal_y_ff  <= csr_wdata;
            fpp_pkg::REG_CENTER_X: center_x_ff <= csr_wdata;
            fpp_pkg::REG_CENTER_Y: center_y_ff <= csr_wdata;
            fpp_pkg::REG_DIST_K1:  k_ff[0]     <= csr_wdata;
            fpp_pkg::REG_DIST_K2:  k_ff[1]     <= csr_wdata;
            fpp_pkg::REG_DIST_K3:  k_ff[2]     <= csr_wdata;
            fpp_pkg::REG_DIST_K4:  k_ff[3]     <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic run;
   logic skid_valid_ff;
   assign run       = !skid_valid_ff;
   assign req_ready = run;

   // stage valids
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff;
   logic f_valid_ff, g_valid_ff, h_valid_ff, i_valid_ff, j_valid_ff;
   logic k_valid_ff, l_valid_ff, m_valid_ff, n_valid_ff, o_valid_ff;
   logic p_valid_ff, q_valid_ff, r_valid_ff, s_valid_ff, t_valid_ff;
   logic sq_valid, cd_valid;

   // stage a: magnitudes and direction signs
   logic [31:0] a_ax_ff, a_ay_ff, a_az_ff;
   fpp_pkg::flags_type a_flags_ff;
   logic [31:0] z_fix;
   assign z_fix = (req_point_z == 32'sd0) ? 32'd1 : req_point_z;

   always_ff @(posedge clock) begin
      if (run) begin
         a_ax_ff <= req_point_x[31] ? (~req_point_x + 32'd1) : req_point_x;
         a_ay_ff <= req_point_y[31] ? (~req_point_y + 32'd1) : req_point_y;
         a_az_ff <= z_fix[31] ? (~z_fix + 32'd1) : z_fix;
         a_flags_ff.neg_x <= req_point_x[31] ^ z_fix[31];
         a_flags_ff.neg_y <= req_point_y[31] ^ z_fix[31];
         a_flags_ff.zr    <= 1'b0;
      end
   end

   // stage b: squares
   logic [63:0] b_sqx_ff, b_sqy_ff;
   logic [31:0] b_ax_ff, b_ay_ff, b_az_ff;
   fpp_pkg::flags_type b_flags_ff;
   always_ff @(posedge clock) begin
      if (run) begin
         b_sqx_ff   <= a_ax_ff * a_ax_ff;
         b_sqy_ff   <= a_ay_ff * a_ay_ff;
         b_ax_ff    <= a_ax_ff;
         b_ay_ff    <= a_ay_ff;
         b_az_ff    <= a_az_ff;
         b_flags_ff <= a_flags_ff;
      end
   end

   // stage c: squared radius
   logic [63:0] c_sum_ff;
   logic [31:0] c_ax_ff, c_ay_ff, c_az_ff;
   fpp_pkg::flags_type c_flags_ff;
   always_ff @(posedge clock) begin
      if (run) begin
         c_sum_ff   <= b_sqx_ff + b_sqy_ff;
         c_ax_ff    <= b_ax_ff;
         c_ay_ff    <= b_ay_ff;
         c_az_ff    <= b_az_ff;
         c_flags_ff <= b_flags_ff;
      end
   end

   // stage d: even normalizing shift that brings the sum to 2^60 or above
   logic [5:0] c_msb;
   logic [5:0] c_shift;
   assign c_msb   = fpp_pkg::msb_index(c_sum_ff);
   assign c_shift = (c_msb >= 6'd60) ? 6'd0 : ((6'd61 - c_msb) & 6'b111110);

   logic [63:0] d_sum_ff;
   logic [5:0]  d_shift_ff;
   logic [31:0] d_ax_ff, d_ay_ff, d_az_ff;
   fpp_pkg::flags_type d_flags_ff;
   always_ff @(posedge clock) begin
      if (run) begin
         d_sum_ff         <= c_sum_ff;
         d_shift_ff       <= c_shift;
         d_ax_ff          <= c_ax_ff;
         d_ay_ff          <= c_ay_ff;
         d_az_ff          <= c_az_ff;
         d_flags_ff.neg_x <= c_flags_ff.neg_x;
         d_flags_ff.neg_y <= c_flags_ff.neg_y;
         d_flags_ff.zr    <= (c_sum_ff == 64'd0);
      end
   end

   // stage e: apply shift to the sum and half of it to the axes
   logic [4:0] d_half;
   assign d_half = d_shift_ff[5:1];

   logic [63:0] e_rad_ff;
   fpp_pkg::sq_side_type e_side_ff;
   always_ff @(posedge clock) begin
      if (run) begin
         e_rad_ff        <= d_sum_ff << d_shift_ff;
         e_side_ff.flags <= d_flags_ff;
         e_side_ff.ax    <= d_ax_ff << d_half;
         e_side_ff.ay    <= d_ay_ff << d_half;
         e_side_ff.az    <= {31'd0, d_az_ff} << d_half;
      end
   end

   logic [31:0] sq_root;
   fpp_pkg::sq_side_type sq_side;

   fpp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (run),
      .in_valid  (e_valid_ff),
      .in_rad    (e_rad_ff),
      .in_side   (e_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // stage f: leading bit of the larger cordic input
   logic [62:0] sq_big;
   assign sq_big = (sq_side.az > {31'd0, sq_root}) ? sq_side.az : {31'd0, sq_root};

   logic [62:0] f_xv_ff;
   logic [31:0] f_root_ff, f_ax_ff, f_ay_ff;
   logic [5:0]  f_msb_ff;
   fpp_pkg::flags_type f_flags_ff;
   always_ff @(posedge clock) begin
      if (run) begin
         f_xv_ff    <= sq_side.az;
         f_root_ff  <= sq_root;
         f_ax_ff    <= sq_side.ax;
         f_ay_ff    <= sq_side.ay;
         f_msb_ff   <= fpp_pkg::msb_index({1'b0, sq_big});
         f_flags_ff <= sq_side.flags;
      end
   end

   // stage g: bring the larger input into [2^60, 2^61)
   logic [63:0] f_xw, f_yw, f_xs, f_ys;
   assign f_xw = {1'b0, f_xv_ff};
   assign f_yw = {32'd0, f_root_ff};
   always_comb begin
      if (f_msb_ff > 6'd60) begin
         f_xs = f_xw >> (f_msb_ff - 6'd60);
         f_ys = f_yw >> (f_msb_ff - 6'd60);
      end else begin
         f_xs = f_xw << (6'd60 - f_msb_ff);
         f_ys = f_yw << (6'd60 - f_msb_ff);
      end
   end

   logic signed [63:0] g_cx_ff, g_cy_ff;
   logic [31:0] g_ax_ff, g_ay_ff, g_div_ff;
   fpp_pkg::flags_type g_flags_ff;
   always_ff @(posedge clock) begin
      if (run) begin
         g_cx_ff    <= $signed(f_xs);
         g_cy_ff    <= $signed(f_ys);
         g_ax_ff    <= f_ax_ff;
         g_ay_ff    <= f_ay_ff;
         g_div_ff   <= f_root_ff;
         g_flags_ff <= f_flags_ff;
      end
   end

   logic signed [33:0] cd_ang;
   logic [31:0] cd_ux, cd_uy;
   fpp_pkg::flags_type cd_flags;

   fpp_cordic_div u_cordic_div (
      .clock     (clock),
      .reset     (reset),
      .en        (run),
      .in_valid  (g_valid_ff),
      .in_cx     (g_cx_ff),
      .in_cy     (g_cy_ff),
      .in_ax     (g_ax_ff),
      .in_ay     (g_ay_ff),
      .in_div    (g_div_ff),
      .in_flags  (g_flags_ff),
      .out_valid (cd_valid),
      .out_ang   (cd_ang),
      .out_ux    (cd_ux),
      .out_uy    (cd_uy),
      .out_flags (cd_flags)
   );

   // stage h: clamp angle to a quarter turn, convert to radians
   logic [30:0] cd_angc;
   always_comb begin
      if (cd_ang[33]) begin
         cd_angc = '0;
      end else if (cd_ang > 34'sd1073741824) begin
         cd_angc = 31'd1073741824;
      end else begin
         cd_angc = cd_ang[30:0];
      end
   end

   logic [63:0] h_prod_ff;
   logic [31:0] h_ux_ff, h_uy_ff;
   fpp_pkg::flags_type h_flags_ff;
   always_ff @(posedge clock) begin
      if (run) begin
         h_prod_ff  <= cd_angc * fpp_pkg::PI_Q31;
         h_ux_ff    <= cd_ux;
         h_uy_ff    <= cd_uy;
         h_flags_ff <= cd_flags;
      end
   end

   // stage i: theta in Q.30
   logic [64:0] h_rnd;
   assign h_rnd = {1'b0, h_prod_ff} + (65'd1 << 31);

   logic [30:0] i_t_ff;
   logic [31:0] i_ux_ff, i_uy_ff;
   fpp_pkg::flags_type i_flags_ff;
   always_ff @(posedge clock) begin
      if (run) begin
         i_t_ff     <= h_rnd[62:32];
         i_ux_ff    <= h_ux_ff;
         i_uy_ff    <= h_uy_ff;
         i_flags_ff <= h_flags_ff;
      end
   end

   // stage j: theta squared
   logic [62:0] i_sq;
   assign i_sq = i_t_ff * i_t_ff + (63'd1 << 29);

   logic [30:0] j_t_ff;
   logic [31:0] j_th2_ff, j_ux_ff, j_uy_ff;
   fpp_pkg::flags_type j_flags_ff;
   always_ff @(posedge clock) begin
      if (run) begin
         j_th2_ff   <= i_sq[61:30];
         j_t_ff     <= i_t_ff;
         j_ux_ff    <= i_ux_ff;
         j_uy_ff    <= i_uy_ff;
         j_flags_ff <= i_flags_ff;
      end
   end

   // stage k: theta^4
   logic [64:0] j_sq;
   assign j_sq = j_th2_ff * j_th2_ff + (65'd1 << 29);

   logic [30:0] k_t_ff;
   logic [31:0] k_th2_ff, k_ux_ff, k_uy_ff;
   logic [32:0] k_th4_ff;
   fpp_pkg::flags_type k_flags_ff;
   always_ff @(posedge clock) begin
      if (run) begin
         k_th4_ff   <= j_sq[62:30];
         k_th2_ff   <= j_th2_ff;
         k_t_ff     <= j_t_ff;
         k_ux_ff    <= j_ux_ff;
         k_uy_ff    <= j_uy_ff;
         k_flags_ff <= j_flags_ff;
      end
   end

   // stage l: theta^6 and theta^8
   logic [65:0] k_p6, k_p8;
   assign k_p6 = k_th4_ff * k_th2_ff + (66'd1 << 29);
   assign k_p8 = k_th4_ff * k_th4_ff + (66'd1 << 29);

   logic [35:0] l_pw_ff [4];
   logic [30:0] l_t_ff;
   logic [31:0] l_ux_ff, l_uy_ff;
   fpp_pkg::flags_type l_flags_ff;
   always_ff @(posedge clock) begin
      if (run) begin
         l_pw_ff[0] <= {4'd0, k_th2_ff};
         l_pw_ff[1] <= {3'd0, k_th4_ff};
         l_pw_ff[2] <= {2'd0, k_p6[63:30]};
         l_pw_ff[3] <= k_p8[65:30];
         l_t_ff     <= k_t_ff;
         l_ux_ff    <= k_ux_ff;
         l_uy_ff    <= k_uy_ff;
         l_flags_ff <= k_flags_ff;
      end
   end

   // stage m: coefficient terms, magnitude rounded then signed
   logic [37:0] l_term [4];
   always_comb begin
      logic [31:0] km;
      logic [67:0] tp;
      for (int n = 0; n < 4; n++) begin
         km        = k_ff[n][31] ? (~k_ff[n] + 32'd1) : k_ff[n];
         tp        = km * l_pw_ff[n] + (68'd1 << 29);
         l_term[n] = tp[67:30];
      end
   end

   logic [37:0] m_term_ff [4];
   logic [3:0]  m_tneg_ff;
   logic [30:0] m_t_ff;
   logic [31:0] m_ux_ff, m_uy_ff;
   fpp_pkg::flags_type m_flags_ff;
   always_ff @(posedge clock) begin
      if (run) begin
         for (int n = 0; n < 4; n++) begin
            m_term_ff[n] <= l_term[n];
            m_tneg_ff[n] <= k_ff[n][31];
         end
         m_t_ff     <= l_t_ff;
         m_ux_ff    <= l_ux_ff;
         m_uy_ff    <= l_uy_ff;
         m_flags_ff <= l_flags_ff;
      end
   end

   // stage n: polynomial
   logic [41:0] m_poly;
   always_comb begin
      m_poly = fpp_pkg::ONE_Q28;
      for (int n = 0; n < 4; n++) begin
         if (m_tneg_ff[n]) begin
            m_poly = m_poly - {4'd0, m_term_ff[n]};
         end else begin
            m_poly = m_poly + {4'd0, m_term_ff[n]};
         end
      end
   end

   logic [41:0] n_poly_ff;
   logic [30:0] n_t_ff;
   logic [31:0] n_ux_ff, n_uy_ff;
   fpp_pkg::flags_type n_flags_ff;
   always_ff @(posedge clock) begin
      if (run) begin
         n_poly_ff  <= m_poly;
         n_t_ff     <= m_t_ff;
         n_ux_ff    <= m_ux_ff;
         n_uy_ff    <= m_uy_ff;
         n_flags_ff <= m_flags_ff;
      end
   end

   // stage o: theta times |poly|, two partial products
   logic [41:0] n_pmag;
   assign n_pmag = n_poly_ff[41] ? (~n_poly_ff + 42'd1) : n_poly_ff;

   logic [51:0] o_lo_ff;
   logic [50:0] o_hi_ff;
   logic [31:0] o_ux_ff, o_uy_ff;
   fpp_pkg::flags_type o_flags_ff;
   always_ff @(posedge clock) begin
      if (run) begin
         o_lo_ff          <= n_t_ff * n_pmag[20:0];
         o_hi_ff          <= n_t_ff * n_pmag[40:21];
         o_ux_ff          <= n_ux_ff;
         o_uy_ff          <= n_uy_ff;
         o_flags_ff.neg_x <= n_flags_ff.neg_x ^ n_poly_ff[41];
         o_flags_ff.neg_y <= n_flags_ff.neg_y ^ n_poly_ff[41];
         o_flags_ff.zr    <= n_flags_ff.zr;
      end
   end

   // stage p: distorted angle, zero for a point on the axis
   logic [73:0] o_td;
   assign o_td = 74'(o_lo_ff) + (74'(o_hi_ff) << 21) + (74'd1 << 25);

   logic [47:0] p_td_ff;
   logic [31:0] p_ux_ff, p_uy_ff;
   fpp_pkg::flags_type p_flags_ff;
   always_ff @(posedge clock) begin
      if (run) begin
         p_td_ff    <= o_flags_ff.zr ? 48'd0 : o_td[73:26];
         p_ux_ff    <= o_ux_ff;
         p_uy_ff    <= o_uy_ff;
         p_flags_ff <= o_flags_ff;
      end
   end

   // stage q: direction times angle, partial products
   logic [55:0] q_xlo_ff, q_xhi_ff, q_ylo_ff, q_yhi_ff;
   fpp_pkg::flags_type q_flags_ff;
   always_ff @(posedge clock) begin
      if (run) begin
         q_xlo_ff   <= p_ux_ff * p_td_ff[23:0];
         q_xhi_ff   <= p_ux_ff * p_td_ff[47:24];
         q_ylo_ff   <= p_uy_ff * p_td_ff[23:0];
         q_yhi_ff   <= p_uy_ff * p_td_ff[47:24];
         q_flags_ff <= p_flags_ff;
      end
   end

   // stage r
   logic [79:0] q_dx, q_dy;
   assign q_dx = 80'(q_xlo_ff) + (80'(q_xhi_ff) << 24) + (80'd1 << 30);
   assign q_dy = 80'(q_ylo_ff) + (80'(q_yhi_ff) << 24) + (80'd1 << 30);

   logic [47:0] r_dx_ff, r_dy_ff;
   fpp_pkg::flags_type r_flags_ff;
   always_ff @(posedge clock) begin
      if (run) begin
         r_dx_ff    <= q_dx[78:31];
         r_dy_ff    <= q_dy[78:31];
         r_flags_ff <= q_flags_ff;
      end
   end

   // stage s: focal scaling, partial products
   logic [55:0] s_xlo_ff, s_xhi_ff, s_ylo_ff, s_yhi_ff;
   fpp_pkg::flags_type s_flags_ff;
   always_ff @(posedge clock) begin
      if (run) begin
         s_xlo_ff   <= r_dx_ff[23:0] * focal_x_ff;
         s_xhi_ff   <= r_dx_ff[47:24] * focal_x_ff;
         s_ylo_ff   <= r_dy_ff[23:0] * focal_y_ff;
         s_yhi_ff   <= r_dy_ff[47:24] * focal_y_ff;
         s_flags_ff <= r_flags_ff;
      end
   end

   // stage t
   logic [79:0] s_sx, s_sy;
   assign s_sx = 80'(s_xlo_ff) + (80'(s_xhi_ff) << 24) + (80'd1 << 31);
   assign s_sy = 80'(s_ylo_ff) + (80'(s_yhi_ff) << 24) + (80'd1 << 31);

   logic [47:0] t_sx_ff, t_sy_ff;
   fpp_pkg::flags_type t_flags_ff;
   always_ff @(posedge clock) begin
      if (run) begin
         t_sx_ff    <= s_sx[79:32];
         t_sy_ff    <= s_sy[79:32];
         t_flags_ff <= s_flags_ff;
      end
   end

   // principal point and saturation
   logic [49:0] vx, vy;
   logic [31:0] px, py;
   logic        clip_x, clip_y;
   assign vx = t_flags_ff.neg_x
             ? {{18{center_x_ff[31]}}, center_x_ff} - {2'b00, t_sx_ff}
             : {{18{center_x_ff[31]}}, center_x_ff} + {2'b00, t_sx_ff};
   assign vy = t_flags_ff.neg_y
             ? {{18{center_y_ff[31]}}, center_y_ff} - {2'b00, t_sy_ff}
             : {{18{center_y_ff[31]}}, center_y_ff} + {2'b00, t_sy_ff};

   always_comb begin
      clip_x = 1'b0;
      px     = vx[31:0];
      if (!vx[49] && (vx[48:31] != 18'd0)) begin
         px     = 32'h7FFFFFFF;
         clip_x = 1'b1;
      end else if (vx[49] && (vx[48:31] != 18'h3FFFF)) begin
         px     = 32'h80000000;
         clip_x = 1'b1;
      end
   end

   always_comb begin
      clip_y = 1'b0;
      py     = vy[31:0];
      if (!vy[49] && (vy[48:31] != 18'd0)) begin
         py     = 32'h7FFFFFFF;
         clip_y = 1'b1;
      end else if (vy[49] && (vy[48:31] != 18'h3FFFF)) begin
         py     = 32'h80000000;
         clip_y = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         i_valid_ff <= 1'b0;
         j_valid_ff <= 1'b0;
         k_valid_ff <= 1'b0;
         l_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         n_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         q_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         t_valid_ff <= 1'b0;
      end else if (run) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= sq_valid;
         g_valid_ff <= f_valid_ff;
         h_valid_ff <= cd_valid;
         i_valid_ff <= h_valid_ff;
         j_valid_ff <= i_valid_ff;
         k_valid_ff <= j_valid_ff;
         l_valid_ff <= k_valid_ff;
         m_valid_ff <= l_valid_ff;
         n_valid_ff <= m_valid_ff;
         o_valid_ff <= n_valid_ff;
         p_valid_ff <= o_valid_ff;
         q_valid_ff <= p_valid_ff;
         r_valid_ff <= q_valid_ff;
         s_valid_ff <= r_valid_ff;
         t_valid_ff <= s_valid_ff;
      end
   end

   // output register and skid word
   logic        out_valid_ff;
   logic [31:0] out_px_ff, out_py_ff, skid_px_ff, skid_py_ff;
   logic        out_clip_ff, skid_clip_ff;
   logic        take, push;
   assign take = out_valid_ff && rsp_ready;
   assign push = run && t_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_px_ff   <= skid_px_ff;
            out_py_ff   <= skid_py_ff;
            out_clip_ff <= skid_clip_ff;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_px_ff   <= px;
            out_py_ff   <= py;
            out_clip_ff <= clip_x | clip_y;
         end else begin
            skid_px_ff   <= px;
            skid_py_ff   <= py;
            skid_clip_ff <= clip_x | clip_y;
         end
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_pixel_x = $signed(out_px_ff);
   assign rsp_pixel_y = $signed(out_py_ff);
   assign rsp_clipped = out_clip_ff;

endmodule

FILE: design/fpp_sqrt.sv
// ----------------------------------------------------------------------------
// fpp_sqrt
// pipelined digit-by-digit integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module fpp_sqrt (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [63:0]          in_rad,
   input  fpp_pkg::sq_side_type in_side,
   output logic                 out_valid,
   output logic [31:0]          out_root,
   output fpp_pkg::sq_side_type out_side
);

   localparam int Steps = fpp_pkg::SQRT_STEPS;

   logic                 valid_ff [Steps];
   logic [63:0]          rem_ff   [Steps];
   logic [63:0]          root_ff  [Steps];
   fpp_pkg::sq_side_type side_ff  [Steps];

   for (genvar i = 0; i < Steps; i++) begin : g_step
      localparam logic [63:0] StepBit = 64'd1 << (62 - 2 * i);
      logic                 valid_cur;
      logic [63:0]          rem_cur;
      logic [63:0]          root_cur;
      fpp_pkg::sq_side_type side_cur;
      logic [63:0]          trial;
      logic [63:0]          rem_in;
      logic [63:0]          root_in;

      if (i == 0) begin : g_head
         assign valid_cur = in_valid;
         assign rem_cur   = in_rad;
         assign root_cur  = '0;
         assign side_cur  = in_side;
      end else begin : g_tail
         assign valid_cur = valid_ff[i-1];
         assign rem_cur   = rem_ff[i-1];
         assign root_cur  = root_ff[i-1];
         assign side_cur  = side_ff[i-1];
      end

      assign trial = root_cur + StepBit;

      always_comb begin
         if (rem_cur >= trial) begin
            rem_in  = rem_cur - trial;
            root_in = (root_cur >> 1) + StepBit;
         end else begin
            rem_in  = rem_cur;
            root_in = root_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            side_ff[i] <= side_cur;
         end
      end
   end

   assign out_valid = valid_ff[Steps-1];
   assign out_root  = root_ff[Steps-1][31:0];
   assign out_side  = side_ff[Steps-1];

endmodule

FILE: design/fpp_cordic_div.sv
// ----------------------------------------------------------------------------
// fpp_cordic_div
// vectoring cordic for the ray angle, run in lock step with two restoring
// dividers that form the unit direction, one step of each per stage
// ----------------------------------------------------------------------------
module fpp_cordic_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [63:0] in_cx,
   input  logic signed [63:0] in_cy,
   input  logic [31:0]        in_ax,
   input  logic [31:0]        in_ay,
   input  logic [31:0]        in_div,
   input  fpp_pkg::flags_type in_flags,
   output logic               out_valid,
   output logic signed [33:0] out_ang,
   output logic [31:0]        out_ux,
   output logic [31:0]        out_uy,
   output fpp_pkg::flags_type out_flags
);

   localparam int Steps = fpp_pkg::ANG_STEPS;

   logic               valid_ff [Steps];
   logic signed [63:0] cx_ff    [Steps];
   logic signed [63:0] cy_ff    [Steps];
   logic signed [33:0] ang_ff   [Steps];
   logic [33:0]        rx_ff    [Steps];
   logic [33:0]        ry_ff    [Steps];
   logic [31:0]        qx_ff    [Steps];
   logic [31:0]        qy_ff    [Steps];
   logic [31:0]        div_ff   [Steps];
   fpp_pkg::flags_type flags_ff [Steps];

   for (genvar i = 0; i < Steps; i++) begin : g_step
      logic               valid_cur;
      logic signed [63:0] cx_cur;
      logic signed [63:0] cy_cur;
      logic signed [33:0] ang_cur;
      logic [33:0]        rx_cur;
      logic [33:0]        ry_cur;
      logic [31:0]        qx_cur;
      logic [31:0]        qy_cur;
      logic [31:0]        div_cur;
      fpp_pkg::flags_type flags_cur;
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic signed [33:0] step_ang;
      logic [33:0]        div_ext;
      logic               ge_x;
      logic               ge_y;
      logic [33:0]        rnx;
      logic [33:0]        rny;
      logic signed [63:0] cx_in;
      logic signed [63:0] cy_in;
      logic signed [33:0] ang_in;

      if (i == 0) begin : g_head
         assign valid_cur = in_valid;
         assign cx_cur    = in_cx;
         assign cy_cur    = in_cy;
         assign ang_cur   = '0;
         assign rx_cur    = {2'b00, in_ax};
         assign ry_cur    = {2'b00, in_ay};
         assign qx_cur    = '0;
         assign qy_cur    = '0;
         assign div_cur   = in_div;
         assign flags_cur = in_flags;
      end else begin : g_tail
         assign valid_cur = valid_ff[i-1];
         assign cx_cur    = cx_ff[i-1];
         assign cy_cur    = cy_ff[i-1];
         assign ang_cur   = ang_ff[i-1];
         assign rx_cur    = rx_ff[i-1];
         assign ry_cur    = ry_ff[i-1];
         assign qx_cur    = qx_ff[i-1];
         assign qy_cur    = qy_ff[i-1];
         assign div_cur   = div_ff[i-1];
         assign flags_cur = flags_ff[i-1];
      end

      assign dx       = cy_cur >>> i;
      assign dy       = cx_cur >>> i;
      assign step_ang = $signed({2'b00, fpp_pkg::ATAN_BAM[i]});

      // rotate toward the x axis
      always_comb begin
         if (!cy_cur[63]) begin
            cx_in  = cx_cur + dx;
            cy_in  = cy_cur - dy;
            ang_in = ang_cur + step_ang;
         end else begin
            cx_in  = cx_cur - dx;
            cy_in  = cy_cur + dy;
            ang_in = ang_cur - step_ang;
         end
      end

      assign div_ext = {2'b00, div_cur};
      assign ge_x    = rx_cur >= div_ext;
      assign ge_y    = ry_cur >= div_ext;
      assign rnx     = ge_x ? rx_cur - div_ext : rx_cur;
      assign rny     = ge_y ? ry_cur - div_ext : ry_cur;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cx_ff[i]    <= cx_in;
            cy_ff[i]    <= cy_in;
            ang_ff[i]   <= ang_in;
            rx_ff[i]    <= {rnx[32:0], 1'b0};
            ry_ff[i]    <= {rny[32:0], 1'b0};
            qx_ff[i]    <= {qx_cur[30:0], ge_x};
            qy_ff[i]    <= {qy_cur[30:0], ge_y};
            div_ff[i]   <= div_cur;
            flags_ff[i] <= flags_cur;
         end
      end
   end

   assign out_valid = valid_ff[Steps-1];
   assign out_ang   = ang_ff[Steps-1];
   assign out_ux    = qx_ff[Steps-1];
   assign out_uy    = qy_ff[Steps-1];
   assign out_flags = flags_ff[Steps-1];

endmodule
